### hdl/dual_motor_stall_homing_gripper_core_defines.svh
// ----------------------------------------------------------------------------
// Gripper core assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_MOTOR_STALL_HOMING_GRIPPER_CORE_DEFINES_SVH
`define DUAL_MOTOR_STALL_HOMING_GRIPPER_CORE_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define DMSHG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define DMSHG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dmshg_pkg.sv
// ----------------------------------------------------------------------------
// Gripper core package
// Word types, sequencing phases and register indices for the gripper core.
// ----------------------------------------------------------------------------
package dmshg_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int CNT_W      = 6;

	typedef struct packed {
		logic signed [15:0] speed_a;
		logic signed [31:0] position_a;
		logic signed [15:0] speed_b;
		logic signed [31:0] position_b;
		logic               close_cmd;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] current_a;
		logic signed [15:0] current_b;
		logic               done_res;
		logic               ready_res;
	} out_item_t;

	typedef enum logic [1:0] {
		PH_RUN        = 2'd0,
		PH_INIT_CLOSE = 2'd1,
		PH_INIT_OPEN  = 2'd2,
		PH_SPARE      = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STALL_SPEED_A = 3'd0,
		REG_STALL_SPEED_B = 3'd1,
		REG_OPEN_OFFSET_A = 3'd2,
		REG_OPEN_OFFSET_B = 3'd3,
		REG_DRIVE_CURRENT = 3'd4,
		REG_ARRIVE_TOL    = 3'd5
	} reg_idx_t;

	localparam logic [15:0]      TOL_RESET = 16'd100;
	localparam logic [CNT_W-1:0] CNT_MAX   = '1;

endpackage

### hdl/dual_motor_stall_homing_gripper_core.sv
// ----------------------------------------------------------------------------
// Dual motor stall homing gripper core
// Each accepted word is registered in item_s1, and its result word in out_data.
// Throughput: one word per cycle while the result side keeps taking words.
// The state update of one tick sits between the input and result registers.
// Reset starts in the initial close phase, arrive tolerance 100, other state zero.
// ----------------------------------------------------------------------------
`include "dual_motor_stall_homing_gripper_core_defines.svh"

module dual_motor_stall_homing_gripper_core #(
	parameter int STALL_TICKS = 50,
	parameter int POS_WIDTH   = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  dmshg_pkg::in_item_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output dmshg_pkg::out_item_t                 out_data,
	input  logic                                 cfg_we,
	input  logic [dmshg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dmshg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	localparam int PW1 = POS_WIDTH + 1;
	localparam logic [dmshg_pkg::CNT_W-1:0] STALL_LIM = dmshg_pkg::CNT_W'(STALL_TICKS);

	function automatic logic speed_over(logic signed [15:0] spd, logic [14:0] thr);
		logic signed [16:0] sx;
		logic [16:0]        mag;
		sx  = 17'(spd);
		mag = sx[16] ? unsigned'(-sx) : unsigned'(sx);
		return mag > {2'b00, thr};
	endfunction

	function automatic logic near_tgt(logic [POS_WIDTH-1:0] pos, logic [POS_WIDTH-1:0] tgt,
			logic [15:0] tol);
		logic [POS_WIDTH-1:0] d;
		logic signed [POS_WIDTH:0] dx;
		logic [POS_WIDTH:0] mag;
		d   = pos - tgt;
		dx  = signed'({d[POS_WIDTH-1], d});
		mag = dx[POS_WIDTH] ? unsigned'(-dx) : unsigned'(dx);
		return mag < PW1'(tol);
	endfunction

	function automatic logic [dmshg_pkg::CNT_W-1:0] cnt_next(
			logic [dmshg_pkg::CNT_W-1:0] cnt, logic over);
		if (over) begin
			return '0;
		end
		return (cnt == dmshg_pkg::CNT_MAX) ? cnt : cnt + 1'b1;
	endfunction

	// Configuration registers
	logic [14:0]          stall_speed_a_q, stall_speed_b_q;
	logic [POS_WIDTH-1:0] open_offset_a_q, open_offset_b_q;
	logic [15:0]          drive_current_q, arrive_tol_q;

	// Sequencing state
	dmshg_pkg::phase_t           phase_q, phase_d;
	logic [dmshg_pkg::CNT_W-1:0] stall_count_a_q, stall_count_b_q;
	logic [dmshg_pkg::CNT_W-1:0] stall_count_a_d, stall_count_b_d;
	logic [POS_WIDTH-1:0]        open_target_a_q, open_target_b_q;
	logic [POS_WIDTH-1:0]        open_target_a_d, open_target_b_d;
	logic closed_a_q, closed_b_q, opened_a_q, opened_b_q;
	logic closed_a_d, closed_b_d, opened_a_d, opened_b_d;

	// Pipeline
	logic                 v_s1;
	dmshg_pkg::in_item_t  item_s1;
	logic                 adv;
	dmshg_pkg::out_item_t res_d;

	// Tick evaluation
	logic                 do_close, do_open;
	logic                 over_a, over_b, hit_a, hit_b;
	logic                 cl_a, cl_b, close_done;
	logic                 op_a, op_b, open_done;
	logic [POS_WIDTH-1:0] pos_a, pos_b;
	logic [15:0]          neg_current;

	// Checker terms
	logic chk_done, chk_idle, chk_init_open, chk_both_closed, chk_close_adv, chk_run;

	assign adv      = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_speed_a_q <= '0;
			stall_speed_b_q <= '0;
			open_offset_a_q <= '0;
			open_offset_b_q <= '0;
			drive_current_q <= '0;
			arrive_tol_q    <= dmshg_pkg::TOL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dmshg_pkg::REG_STALL_SPEED_A: stall_speed_a_q <= cfg_wdata[14:0];
				dmshg_pkg::REG_STALL_SPEED_B: stall_speed_b_q <= cfg_wdata[14:0];
				dmshg_pkg::REG_OPEN_OFFSET_A: open_offset_a_q <= cfg_wdata[POS_WIDTH-1:0];
				dmshg_pkg::REG_OPEN_OFFSET_B: open_offset_b_q <= cfg_wdata[POS_WIDTH-1:0];
				dmshg_pkg::REG_DRIVE_CURRENT: drive_current_q <= cfg_wdata[15:0];
				dmshg_pkg::REG_ARRIVE_TOL:    arrive_tol_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	assign pos_a       = item_s1.position_a[POS_WIDTH-1:0];
	assign pos_b       = item_s1.position_b[POS_WIDTH-1:0];
	assign neg_current = 16'(-drive_current_q);

	assign do_close = (phase_q == dmshg_pkg::PH_INIT_CLOSE) ||
		(phase_q == dmshg_pkg::PH_RUN && item_s1.close_cmd);
	assign do_open  = (phase_q == dmshg_pkg::PH_INIT_OPEN) ||
		(phase_q == dmshg_pkg::PH_RUN && !item_s1.close_cmd);

	assign over_a     = speed_over(item_s1.speed_a, stall_speed_a_q);
	assign over_b     = speed_over(item_s1.speed_b, stall_speed_b_q);
	assign hit_a      = !over_a && (stall_count_a_q > STALL_LIM);
	assign hit_b      = !over_b && (stall_count_b_q > STALL_LIM);
	assign cl_a       = closed_a_q || hit_a;
	assign cl_b       = closed_b_q || hit_b;
	assign close_done = cl_a && cl_b;

	assign op_a      = opened_a_q || near_tgt(pos_a, open_target_a_q, arrive_tol_q);
	assign op_b      = opened_b_q || near_tgt(pos_b, open_target_b_q, arrive_tol_q);
	assign open_done = op_a && op_b;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			dmshg_pkg::PH_RUN:        phase_d = dmshg_pkg::PH_RUN;
			dmshg_pkg::PH_INIT_CLOSE: if (close_done) phase_d = dmshg_pkg::PH_INIT_OPEN;
			dmshg_pkg::PH_INIT_OPEN:  if (open_done) phase_d = dmshg_pkg::PH_RUN;
			dmshg_pkg::PH_SPARE:      phase_d = dmshg_pkg::PH_INIT_CLOSE;
			default:                  phase_d = dmshg_pkg::PH_INIT_CLOSE;
		endcase
	end

	always_comb begin
		stall_count_a_d = stall_count_a_q;
		stall_count_b_d = stall_count_b_q;
		open_target_a_d = open_target_a_q;
		open_target_b_d = open_target_b_q;
		closed_a_d      = closed_a_q;
		closed_b_d      = closed_b_q;
		opened_a_d      = opened_a_q;
		opened_b_d      = opened_b_q;
		res_d           = '0;
		if (do_close) begin
			stall_count_a_d = cnt_next(stall_count_a_q, over_a);
			stall_count_b_d = cnt_next(stall_count_b_q, over_b);
			if (hit_a) begin
				open_target_a_d = pos_a - open_offset_a_q;
			end
			if (hit_b) begin
				open_target_b_d = pos_b - open_offset_b_q;
			end
			closed_a_d = cl_a;
			closed_b_d = cl_b;
			if (close_done) begin
				opened_a_d = 1'b0;
				opened_b_d = 1'b0;
			end else begin
				res_d.current_a = cl_a ? '0 : drive_current_q;
				res_d.current_b = cl_b ? '0 : drive_current_q;
			end
			res_d.done_res = close_done && (phase_q == dmshg_pkg::PH_RUN);
		end else if (do_open) begin
			opened_a_d = op_a;
			opened_b_d = op_b;
			if (open_done) begin
				closed_a_d = 1'b0;
				closed_b_d = 1'b0;
			end else begin
				res_d.current_a = op_a ? '0 : neg_current;
				res_d.current_b = op_b ? '0 : neg_current;
			end
			res_d.done_res = open_done && (phase_q == dmshg_pkg::PH_RUN);
		end
		res_d.ready_res = (phase_d == dmshg_pkg::PH_RUN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= dmshg_pkg::PH_INIT_CLOSE;
			stall_count_a_q <= '0;
			stall_count_b_q <= '0;
			open_target_a_q <= '0;
			open_target_b_q <= '0;
			closed_a_q      <= 1'b0;
			closed_b_q      <= 1'b0;
			opened_a_q      <= 1'b0;
			opened_b_q      <= 1'b0;
		end else if (adv) begin
			phase_q         <= phase_d;
			stall_count_a_q <= stall_count_a_d;
			stall_count_b_q <= stall_count_b_d;
			open_target_a_q <= open_target_a_d;
			open_target_b_q <= open_target_b_d;
			closed_a_q      <= closed_a_d;
			closed_b_q      <= closed_b_d;
			opened_a_q      <= opened_a_d;
			opened_b_q      <= opened_b_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res_d;
		end
	end

	assign chk_done        = out_valid && out_data.done_res;
	assign chk_idle        = (out_data.current_a == '0) && (out_data.current_b == '0);
	assign chk_init_open   = (phase_q == dmshg_pkg::PH_INIT_OPEN);
	assign chk_both_closed = closed_a_q && closed_b_q;
	assign chk_close_adv   = adv && (phase_q == dmshg_pkg::PH_INIT_CLOSE);
	assign chk_run         = (phase_q == dmshg_pkg::PH_RUN);

	`DMSHG_ASSERT_IMP(a_done_needs_ready, chk_done, out_data.ready_res, "done without ready")
	`DMSHG_ASSERT_IMP(a_done_zero_current, chk_done, chk_idle, "current on completion")
	`DMSHG_ASSERT_IMP(a_init_open_closed, chk_init_open, chk_both_closed, "jaws not closed")
	`DMSHG_ASSERT_NEXT(a_no_skip_init, chk_close_adv, !chk_run, "open phase skipped")

endmodule
